/* sv/pdtq_pkg.sv */
// Shared types, status codes and defaults for the priority delay task queue.
// No dependencies; every other file refers to this package by scoped names.
package pdtq_pkg;

    localparam int QUEUE_DEPTH = 16;

    localparam int ID_W  = 16;
    localparam int PRI_W = 2;
    localparam int TIM_W = 32;
    localparam int ST_W  = 3;
    localparam int OCC_W = 5;

    localparam logic OP_SUBMIT = 1'b0;
    localparam logic OP_FETCH  = 1'b1;

    localparam logic [PRI_W-1:0] PRI_LOW      = 2'd0;
    localparam logic [PRI_W-1:0] PRI_CRITICAL = 2'd3;

    localparam logic [ST_W-1:0] ST_ACCEPTED   = 3'd0;
    localparam logic [ST_W-1:0] ST_FULL       = 3'd1;
    localparam logic [ST_W-1:0] ST_DISPATCHED = 3'd2;
    localparam logic [ST_W-1:0] ST_EMPTY      = 3'd3;
    localparam logic [ST_W-1:0] ST_NOT_DUE    = 3'd4;

    typedef struct packed {
        logic [ID_W-1:0]  id;
        logic [PRI_W-1:0] pri;
        logic [TIM_W-1:0] rel;
    } t_task;

    typedef struct packed {
        logic             op;
        t_task            tsk;
        logic [TIM_W-1:0] now;
    } t_req;

    typedef struct packed {
        logic [ST_W-1:0]  status;
        t_task            tsk;
        logic [OCC_W-1:0] occ;
    } t_result;

endpackage

/* sv/pdtq_in_if.sv */
// Request channel: valid/ready handshake carrying one submit or fetch beat.
// Depends on pdtq_pkg for field widths.
interface pdtq_in_if;
    logic                          valid;
    logic                          ready;
    logic                          operation;
    logic [pdtq_pkg::ID_W-1:0]     task_id;
    logic [pdtq_pkg::PRI_W-1:0]    priority_req;
    logic [pdtq_pkg::TIM_W-1:0]    release_time;
    logic [pdtq_pkg::TIM_W-1:0]    now;

    modport source (output valid, operation, task_id, priority_req, release_time, now,
                    input ready);
    modport sink   (input valid, operation, task_id, priority_req, release_time, now,
                    output ready);
endinterface

/* sv/pdtq_out_if.sv */
// Result channel: valid/ready handshake carrying one status beat per request.
// Depends on pdtq_pkg for field widths.
interface pdtq_out_if;
    logic                          valid;
    logic                          ready;
    logic [pdtq_pkg::ST_W-1:0]     status;
    logic [pdtq_pkg::ID_W-1:0]     out_task_id;
    logic [pdtq_pkg::PRI_W-1:0]    out_priority;
    logic [pdtq_pkg::TIM_W-1:0]    out_release_time;
    logic [pdtq_pkg::OCC_W-1:0]    occupancy;

    modport source (output valid, status, out_task_id, out_priority, out_release_time,
                    occupancy, input ready);
    modport sink   (input valid, status, out_task_id, out_priority, out_release_time,
                    occupancy, output ready);
endinterface

/* sv/pdtq_queue.sv */
// Sorted slot array: parallel rank compares, registered insert/remove shift, result build.
// Depends on pdtq_pkg for the task, request and result types and status codes.
module pdtq_queue #(
    parameter int DEPTH = pdtq_pkg::QUEUE_DEPTH
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_accept,
    input  pdtq_pkg::t_req     i_req,
    output pdtq_pkg::t_result  o_result
);
    localparam int CW = $clog2(DEPTH + 1);

    pdtq_pkg::t_task r_slot [DEPTH];
    logic [CW-1:0]   r_count;
    logic [CW-1:0]   n_count;

    logic             full;
    logic             empty;
    logic             due;
    logic             push;
    logic             pop;
    logic [DEPTH-1:0] p;

    assign full  = (r_count == CW'(DEPTH));
    assign empty = (r_count == '0);
    assign due   = (r_slot[0].rel <= i_req.now);
    assign push  = i_accept && (i_req.op == pdtq_pkg::OP_SUBMIT) && !full;
    assign pop   = i_accept && (i_req.op == pdtq_pkg::OP_FETCH) && !empty && due;

    // p[i]: the new task lands at or before slot i; monotone over i
    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++) begin : g_slot
            logic ranks;
            always_comb begin
                if (i_req.tsk.pri != r_slot[gi].pri) begin
                    ranks = (i_req.tsk.pri > r_slot[gi].pri);
                end else begin
                    ranks = (i_req.tsk.rel < r_slot[gi].rel);
                end
            end
            assign p[gi] = (CW'(gi) >= r_count) || ranks;
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (push) begin
            if (p[0]) begin
                r_slot[0] <= i_req.tsk;
            end
            for (int i = 1; i < DEPTH; i++) begin
                if (p[i] && !p[i-1]) begin
                    r_slot[i] <= i_req.tsk;
                end else if (p[i]) begin
                    r_slot[i] <= r_slot[i-1];
                end
            end
        end else if (pop) begin
            // advance everything one slot toward the head
            for (int i = 0; i < DEPTH - 1; i++) begin
                r_slot[i] <= r_slot[i+1];
            end
        end
    end

    always_comb begin
        n_count = r_count;
        if (push) begin
            n_count = r_count + CW'(1);
        end else if (pop) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    always_comb begin
        o_result.tsk.id  = '0;
        o_result.tsk.pri = pdtq_pkg::PRI_LOW;
        o_result.tsk.rel = '0;
        o_result.occ     = pdtq_pkg::OCC_W'(n_count);
        if (i_req.op == pdtq_pkg::OP_SUBMIT) begin
            o_result.status = full ? pdtq_pkg::ST_FULL : pdtq_pkg::ST_ACCEPTED;
        end else if (empty) begin
            o_result.status = pdtq_pkg::ST_EMPTY;
        end else if (!due) begin
            o_result.status = pdtq_pkg::ST_NOT_DUE;
        end else begin
            o_result.status = pdtq_pkg::ST_DISPATCHED;
            o_result.tsk    = r_slot[0];
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("queue count above depth");

    a_push_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |=> (r_count == $past(r_count) + CW'(1)))
        else $error("insert did not grow the queue");

    a_pop_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |=> (r_count == $past(r_count) - CW'(1)))
        else $error("dispatch did not shrink the queue");

    a_head_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count >= CW'(2)) |-> (r_slot[0].pri >= r_slot[1].pri))
        else $error("head outranked by second slot");
`endif

endmodule

/* sv/pdtq_out_buf.sv */
// Two-entry output buffer (main register plus skid) between queue and result channel.
// Depends on pdtq_pkg for the result type.
module pdtq_out_buf (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  pdtq_pkg::t_result  i_data,
    output logic               o_ready,
    output logic               o_valid,
    output pdtq_pkg::t_result  o_data,
    input  logic               i_ready
);
    logic              r_main_valid;
    logic              r_skid_valid;
    pdtq_pkg::t_result r_main;
    pdtq_pkg::t_result r_skid;
    logic              take;

    assign o_ready = !r_skid_valid;
    assign o_valid = r_main_valid;
    assign o_data  = r_main;
    assign take    = r_main_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_main_valid || take) begin
            if (r_skid_valid) begin
                r_main_valid <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_main_valid <= i_valid;
            end
        end else if (i_valid) begin
            // hold main, park the new beat
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_main_valid || take) begin
            r_main <= r_skid_valid ? r_skid : i_data;
        end else if (i_valid) begin
            r_skid <= i_data;
        end
    end

endmodule

/* sv/priority_delay_task_queue_core.sv */
// Priority delay task queue: a sorted queue of up to QUEUE_DEPTH tasks, ordered by
// priority (highest first), then by earlier release time, equal keys first in first out.
// One request is accepted every clock cycle while the skid stage is empty; its result
// is registered in the output register, and a skid stage keeps one more beat while the
// result side stalls. That rate comes from the slot array: every slot compares against
// the request in parallel and the whole array shifts at once on insert or dispatch.
// Reset clears only the fill count and the buffer valid flags; no clearing pass runs.
module priority_delay_task_queue_core #(
    parameter int QUEUE_DEPTH = pdtq_pkg::QUEUE_DEPTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    pdtq_in_if.sink    i_in,
    pdtq_out_if.source o_out
);
    pdtq_pkg::t_req    req;
    pdtq_pkg::t_result result;
    pdtq_pkg::t_result out_data;
    logic              accept;
    logic              buf_ready;

    assign i_in.ready = buf_ready;
    assign accept     = i_in.valid && buf_ready;

    assign req.op      = i_in.operation;
    assign req.tsk.id  = i_in.task_id;
    assign req.tsk.pri = i_in.priority_req;
    assign req.tsk.rel = i_in.release_time;
    assign req.now     = i_in.now;

    pdtq_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_req    (req),
        .o_result (result)
    );

    pdtq_out_buf u_out_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (accept),
        .i_data  (result),
        .o_ready (buf_ready),
        .o_valid (o_out.valid),
        .o_data  (out_data),
        .i_ready (o_out.ready)
    );

    assign o_out.status           = out_data.status;
    assign o_out.out_task_id      = out_data.tsk.id;
    assign o_out.out_priority     = out_data.tsk.pri;
    assign o_out.out_release_time = out_data.tsk.rel;
    assign o_out.occupancy        = out_data.occ;

endmodule
